[rtl/core/lcsr_pkg.sv]
// lcsr_pkg: shared types and constants of the longest constant-step run detector
// no dependencies; used by the interfaces and by every module of the block

package lcsr_pkg;

  // default widths of the sample and of the internal index
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned IndexBitsDef  = 16;

  // fixed widths of the result word fields
  localparam int unsigned RunIdxW = 16;
  localparam int unsigned RunLenW = 17;
  localparam int unsigned StepW   = 16;

  // control of the word held in the input stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

[rtl/core/lcsr_in_if.sv]
// lcsr_in_if: sample channel (valid, ready, sample, last)
// depends on lcsr_pkg for the default sample width

interface lcsr_in_if #(
  parameter int unsigned SAMPLE_BITS = lcsr_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

[rtl/core/lcsr_out_if.sv]
// lcsr_out_if: result channel (valid, ready and the run fields)
// depends on lcsr_pkg for the field widths

interface lcsr_out_if;
  logic                             valid;
  logic                             ready;
  logic [lcsr_pkg::RunIdxW-1:0]     run_start;
  logic [lcsr_pkg::RunIdxW-1:0]     run_end;
  logic [lcsr_pkg::RunLenW-1:0]     run_length;
  logic [lcsr_pkg::StepW-1:0]       step_size;
  logic                             overflow;

  modport source (output valid, output run_start, output run_end, output run_length,
                  output step_size, output overflow, input ready);
  modport sink   (input valid, input run_start, input run_end, input run_length,
                  input step_size, input overflow, output ready);
endinterface

[rtl/core/lcsr_in_reg.sv]
// lcsr_in_reg: input register stage of the run detector
// depends on lcsr_pkg and lcsr_in_if

module lcsr_in_reg #(
  parameter int unsigned SAMPLE_BITS = lcsr_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lcsr_in_if.sink                       in_i,
  input  logic                          take_i,
  output lcsr_pkg::stage_ctl_t          ctl_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  lcsr_pkg::stage_ctl_t          ctl_q, ctl_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          load;

  // stage is free when empty or when its word moves on this cycle
  assign in_i.ready = !ctl_q.valid || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    ctl_d = ctl_q;
    if (load) begin
      ctl_d.valid = 1'b1;
      ctl_d.last  = in_i.last;
    end else if (take_i) begin
      ctl_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  // sample payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= in_i.sample;
    end
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;

endmodule

[rtl/core/lcsr_core.sv]
// lcsr_core: run tracking state, best-run selection and result register
// depends on lcsr_pkg and lcsr_out_if

module lcsr_core #(
  parameter int unsigned SAMPLE_BITS = lcsr_pkg::SampleBitsDef,
  parameter int unsigned INDEX_BITS  = lcsr_pkg::IndexBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcsr_pkg::stage_ctl_t          ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          take_o,
  lcsr_out_if.source                    out_o
);

  localparam int unsigned LenW = INDEX_BITS + 1;
  localparam logic [INDEX_BITS-1:0] IdxMax = {INDEX_BITS{1'b1}};

  // run state
  logic [SAMPLE_BITS-1:0] prev_q;
  logic [SAMPLE_BITS-1:0] cur_step_q;
  logic [INDEX_BITS-1:0]  cur_start_q;
  logic [INDEX_BITS-1:0]  idx_q;
  logic                   have_prev_q;
  logic                   have_step_q;
  logic [INDEX_BITS-1:0]  best_start_q;
  logic [INDEX_BITS-1:0]  best_end_q;
  logic [LenW-1:0]        best_len_q;
  logic [SAMPLE_BITS-1:0] best_step_q;
  logic                   ovf_q;

  // result register
  logic                   out_valid_q;
  logic [INDEX_BITS-1:0]  res_start_q;
  logic [INDEX_BITS-1:0]  res_end_q;
  logic [LenW-1:0]        res_len_q;
  logic [SAMPLE_BITS-1:0] res_step_q;
  logic                   res_ovf_q;

  // combinational next values
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]   abs_diff;
  logic [SAMPLE_BITS-1:0] step;
  logic [INDEX_BITS-1:0]  pos;
  logic                   ovf_n;
  logic                   brk;
  logic [LenW-1:0]        len_a;
  logic [LenW-1:0]        len_b;
  logic [INDEX_BITS-1:0]  ns_start;
  logic [SAMPLE_BITS-1:0] ns_step;
  logic [INDEX_BITS-1:0]  b1_start, b2_start;
  logic [INDEX_BITS-1:0]  b1_end, b2_end;
  logic [LenW-1:0]        b1_len, b2_len;
  logic [SAMPLE_BITS-1:0] b1_step, b2_step;
  logic                   emit;

  // a last word may only move on when the result register can take it
  assign take_o = ctl_i.valid && (!ctl_i.last || !out_valid_q || out_o.ready);
  assign emit   = take_o && ctl_i.last;

  // absolute step to the previous sample
  assign diff     = {sample_i[SAMPLE_BITS-1], sample_i} - {prev_q[SAMPLE_BITS-1], prev_q};
  assign abs_diff = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
  assign step     = abs_diff[SAMPLE_BITS-1:0];

  always_comb begin
    // index of this sample, saturating
    pos   = '0;
    ovf_n = ovf_q;
    if (have_prev_q) begin
      if (idx_q == IdxMax) begin
        pos   = IdxMax;
        ovf_n = 1'b1;
      end else begin
        pos = idx_q + 1'b1;
      end
    end

    // run broken by a new step: offer the closed run
    brk      = have_prev_q && have_step_q && (step != cur_step_q);
    len_a    = LenW'(idx_q) - LenW'(cur_start_q) + LenW'(1);
    b1_start = best_start_q;
    b1_end   = best_end_q;
    b1_len   = best_len_q;
    b1_step  = best_step_q;
    if (brk && (len_a > best_len_q)) begin
      b1_start = cur_start_q;
      b1_end   = idx_q;
      b1_len   = len_a;
      b1_step  = cur_step_q;
    end

    // open run after this sample
    ns_start = cur_start_q;
    ns_step  = cur_step_q;
    if (!have_prev_q) begin
      ns_start = '0;
      ns_step  = '0;
    end else if (!have_step_q || brk) begin
      ns_start = idx_q;
      ns_step  = step;
    end

    // end of sequence: offer the open run too
    len_b    = LenW'(pos) - LenW'(ns_start) + LenW'(1);
    b2_start = b1_start;
    b2_end   = b1_end;
    b2_len   = b1_len;
    b2_step  = b1_step;
    if (len_b > b1_len) begin
      b2_start = ns_start;
      b2_end   = pos;
      b2_len   = len_b;
      b2_step  = ns_step;
    end
  end

  // state update, cleared after the last word of a sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      cur_step_q   <= '0;
      cur_start_q  <= '0;
      idx_q        <= '0;
      have_prev_q  <= 1'b0;
      have_step_q  <= 1'b0;
      best_start_q <= '0;
      best_end_q   <= '0;
      best_len_q   <= '0;
      best_step_q  <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take_o) begin
        if (ctl_i.last) begin
          prev_q       <= '0;
          cur_step_q   <= '0;
          cur_start_q  <= '0;
          idx_q        <= '0;
          have_prev_q  <= 1'b0;
          have_step_q  <= 1'b0;
          best_start_q <= '0;
          best_end_q   <= '0;
          best_len_q   <= '0;
          best_step_q  <= '0;
          ovf_q        <= 1'b0;
        end else begin
          prev_q       <= sample_i;
          cur_step_q   <= ns_step;
          cur_start_q  <= ns_start;
          idx_q        <= pos;
          have_prev_q  <= 1'b1;
          have_step_q  <= have_prev_q || have_step_q;
          best_start_q <= b1_start;
          best_end_q   <= b1_end;
          best_len_q   <= b1_len;
          best_step_q  <= b1_step;
          ovf_q        <= ovf_n;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_start_q <= b2_start;
      res_end_q   <= b2_end;
      res_len_q   <= b2_len;
      res_step_q  <= b2_step;
      res_ovf_q   <= ovf_n;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.run_start  = lcsr_pkg::RunIdxW'(res_start_q);
  assign out_o.run_end    = lcsr_pkg::RunIdxW'(res_end_q);
  assign out_o.run_length = lcsr_pkg::RunLenW'(res_len_q);
  assign out_o.step_size  = lcsr_pkg::StepW'(res_step_q);
  assign out_o.overflow   = res_ovf_q;

endmodule

[rtl/core/longest_constant_step_run.sv]
// longest_constant_step_run: top level of the longest constant-step run detector
// depends on lcsr_pkg, lcsr_in_if, lcsr_out_if, lcsr_in_reg and lcsr_core
//
// Usage
//   in_i  : one signed sample per word, last flags the final sample of a sequence
//   out_o : one result word per sequence (start, end, length, step, overflow)
//   A sample word is taken every cycle unless the input stalls as described below.
//   It is loaded into the input register; the run state and the best run are
//   updated from there. The result of a sequence appears in the result register
//   in the cycle after its last sample is taken and is held until out_o.ready.
//   Throughput: one sample per cycle outside such stalls, set by the state update
//   (one subtract for the step, two length compares).
//   While a result waits, samples keep flowing; only a following last sample is
//   held in the input register until the result register frees up, and the input
//   then stalls behind it.
//   Reset clears the run state and the valid flags of the input and result registers.
//   Indices saturate at 2**INDEX_BITS - 1 and then raise the overflow flag.

module longest_constant_step_run #(
  parameter int unsigned SAMPLE_BITS = lcsr_pkg::SampleBitsDef,
  parameter int unsigned INDEX_BITS  = lcsr_pkg::IndexBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcsr_in_if.sink    in_i,
  lcsr_out_if.source out_o
);

  lcsr_pkg::stage_ctl_t          ctl;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          take;

  // input register stage
  lcsr_in_reg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .take_i   (take),
    .ctl_o    (ctl),
    .sample_o (sample)
  );

  // run tracking and result register
  lcsr_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (sample),
    .take_o   (take),
    .out_o    (out_o)
  );

  // a result only shows up after a last word left the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(take && ctl.last))
    else $error("result without a last sample");

  // input only stalls behind a last word blocked by a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (ctl.valid && ctl.last && out_o.valid && !out_o.ready))
    else $error("input stalled without cause");

  // a taken result with no new one behind it leaves the register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !(take && ctl.last)) |=> !out_o.valid)
    else $error("result word repeated");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for the longest constant-step run detector
// depends on lcsr_pkg, lcsr_in_if, lcsr_out_if and longest_constant_step_run
// directed sequences, then random ones, checked word by word against a predictor

module tb_top;

  localparam int unsigned IdxMax   = (1 << lcsr_pkg::IndexBitsDef) - 1;
  localparam int unsigned HoldLen  = 300;
  localparam int unsigned PhaseLen = 440;

  typedef logic signed [lcsr_pkg::SampleBitsDef-1:0] sample_t;

  typedef struct packed {
    logic [lcsr_pkg::RunIdxW-1:0] start_idx;
    logic [lcsr_pkg::RunIdxW-1:0] end_idx;
    logic [lcsr_pkg::RunLenW-1:0] len;
    logic [lcsr_pkg::StepW-1:0]   step;
    logic                         ovf;
  } run_word_t;

  typedef struct {
    sample_t   smp;
    logic      lst;
    logic      typed;
    run_word_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  lcsr_in_if #(.SAMPLE_BITS(lcsr_pkg::SampleBitsDef)) in_ch ();
  lcsr_out_if out_ch ();

  longest_constant_step_run #(
    .SAMPLE_BITS(lcsr_pkg::SampleBitsDef),
    .INDEX_BITS (lcsr_pkg::IndexBitsDef)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // expected run words, oldest first
  run_word_t   expected_runs[$];
  stim_row_t   dir_rows[$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_samples;
  int unsigned n_seqs;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_tag;

  // run tracker state
  sample_t     prev_smp;
  int unsigned cur_step;
  int unsigned cur_start;
  int unsigned prev_idx;
  logic        seen_first;
  logic        step_known;
  int unsigned best_start;
  int unsigned best_end;
  int unsigned best_len;
  int unsigned best_step;
  logic        idx_sat;

  function automatic run_word_t run_word(int unsigned s, int unsigned e, int unsigned l,
                                         int unsigned st, logic o);
    run_word_t w;
    w.start_idx = s[lcsr_pkg::RunIdxW-1:0];
    w.end_idx   = e[lcsr_pkg::RunIdxW-1:0];
    w.len       = l[lcsr_pkg::RunLenW-1:0];
    w.step      = st[lcsr_pkg::StepW-1:0];
    w.ovf       = o;
    return w;
  endfunction

  function automatic stim_row_t row(sample_t s, logic l);
    stim_row_t r;
    r.smp   = s;
    r.lst   = l;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(sample_t s, run_word_t w);
    stim_row_t r;
    r       = row(s, 1'b1);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  task automatic clear_tracker();
    prev_smp   = '0;
    cur_step   = 0;
    cur_start  = 0;
    prev_idx   = 0;
    seen_first = 1'b0;
    step_known = 1'b0;
    best_start = 0;
    best_end   = 0;
    best_len   = 0;
    best_step  = 0;
    idx_sat    = 1'b0;
  endtask

  // a run replaces the best one only when strictly longer
  task automatic offer_best(int unsigned s, int unsigned e, int unsigned st);
    int unsigned l;
    l = e - s + 1;
    if (l > best_len) begin
      best_start = s;
      best_end   = e;
      best_len   = l;
      best_step  = st;
    end
  endtask

  // advance the run tracker by one sample, report the run word on the last one
  task automatic track_sample(input sample_t s, input logic lst,
                              output logic fired, output run_word_t w);
    int unsigned pos;
    int          d;
    int unsigned stp;
    if (!seen_first) begin
      pos = 0;
    end else if (prev_idx >= IdxMax) begin
      pos     = IdxMax;
      idx_sat = 1'b1;
    end else begin
      pos = prev_idx + 1;
    end
    if (seen_first) begin
      d   = int'(s) - int'(prev_smp);
      stp = (d < 0) ? -d : d;
      if (!step_known) begin
        cur_step   = stp;
        cur_start  = prev_idx;
        step_known = 1'b1;
      end else if (stp != cur_step) begin
        offer_best(cur_start, prev_idx, cur_step);
        cur_start = prev_idx;
        cur_step  = stp;
      end
    end else begin
      cur_start = 0;
      cur_step  = 0;
    end
    prev_smp   = s;
    prev_idx   = pos;
    seen_first = 1'b1;
    fired      = lst;
    w          = '0;
    if (lst) begin
      offer_best(cur_start, pos, step_known ? cur_step : 0);
      w = run_word(best_start, best_end, best_len, best_step, idx_sat);
      clear_tracker();
    end
  endtask

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    n_errors++;
    $display("%0t: result %0d: %s is 0x%0h, expected 0x%0h", $realtime, n_results, field,
             got, want);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: random stalls plus a long hold-off on request
  initial out_ch.ready = 1'b0;
  int unsigned hold_seen;
  int unsigned hold_left;
  initial begin
    hold_seen = 0;
    hold_left = 0;
  end
  always @(negedge clk_i) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HoldLen;
    end
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    run_word_t got;
    run_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = run_word(out_ch.run_start, out_ch.run_end, out_ch.run_length, out_ch.step_size,
                     out_ch.overflow);
      n_results++;
      if (expected_runs.size() == 0) begin
        n_errors++;
        $display("%0t: result word with nothing expected", $realtime);
      end else begin
        want = expected_runs.pop_front();
        if (got.start_idx != want.start_idx)
          report_mismatch("run_start", got.start_idx, want.start_idx);
        if (got.end_idx != want.end_idx)
          report_mismatch("run_end", got.end_idx, want.end_idx);
        if (got.len != want.len)
          report_mismatch("run_length", got.len, want.len);
        if (got.step != want.step)
          report_mismatch("step_size", got.step, want.step);
        if (got.ovf != want.ovf)
          report_mismatch("overflow", got.ovf, want.ovf);
      end
    end
  end

  // send one sample word; called and returns at a falling edge
  task automatic push_sample(sample_t smp, logic lst, logic typed, run_word_t want);
    logic      fired;
    run_word_t w;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    in_ch.last   <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    n_samples++;
    track_sample(smp, lst, fired, w);
    if (fired) begin
      n_seqs++;
      expected_runs.push_back(typed ? want : w);
    end
    @(negedge clk_i);
  endtask

  // random sequence: mostly constant-step segments, some pure noise
  task automatic send_random_sequence(output int unsigned n_sent);
    sample_t     smps[$];
    sample_t     val;
    sample_t     stp;
    int unsigned kind;
    int unsigned seg_len;
    kind = $urandom_range(0, 99);
    val  = sample_t'($urandom);
    smps.push_back(val);
    if (kind < 6) begin
      // single sample sequence
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 4)) begin
        seg_len = $urandom_range(1, 10);
        case ($urandom_range(0, 4))
          0:       stp = '0;
          1, 2, 3: stp = sample_t'($urandom_range(1, 9));
          default: stp = sample_t'($urandom);
        endcase
        repeat (seg_len) begin
          val = $urandom_range(0, 1) ? val + stp : val - stp;
          smps.push_back(val);
        end
      end
    end else begin
      repeat ($urandom_range(1, 16)) smps.push_back(sample_t'($urandom));
    end
    foreach (smps[i]) push_sample(smps[i], i == smps.size() - 1, 1'b0, '0);
    n_sent = smps.size();
  endtask

  // sender pauses until every run word is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, logic with_hold);
    int unsigned sent;
    int unsigned n;
    @(posedge clk_i);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    if (with_hold) hold_tag++;
    @(negedge clk_i);
    sent = 0;
    while (sent < PhaseLen) begin
      send_random_sequence(n);
      sent += n;
    end
    wait_drained();
  endtask

  // stimulus
  initial begin
    n_errors     = 0;
    n_results    = 0;
    n_samples    = 0;
    n_seqs       = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_tag     = 0;
    clear_tracker();
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    rst_ni       = 1'b0;

    // single samples at zero and at the most negative value
    dir_rows.push_back(typed_row(16'sd0, run_word(0, 0, 1, 0, 1'b0)));
    dir_rows.push_back(typed_row(-16'sd32768, run_word(0, 0, 1, 0, 1'b0)));
    // largest possible step, both directions
    dir_rows.push_back(row(-16'sd32768, 1'b0));
    dir_rows.push_back(typed_row(16'sd32767, run_word(0, 1, 2, 65535, 1'b0)));
    dir_rows.push_back(row(16'sd32767, 1'b0));
    dir_rows.push_back(row(-16'sd32768, 1'b0));
    dir_rows.push_back(typed_row(16'sd32767, run_word(0, 2, 3, 65535, 1'b0)));
    // two runs of equal length sharing a sample, the earlier one wins
    dir_rows.push_back(row(16'sd0, 1'b0));
    dir_rows.push_back(row(16'sd1, 1'b0));
    dir_rows.push_back(row(16'sd2, 1'b0));
    dir_rows.push_back(row(16'sd5, 1'b0));
    dir_rows.push_back(typed_row(16'sd8, run_word(0, 2, 3, 1, 1'b0)));
    // a later, strictly longer run takes over
    dir_rows.push_back(row(16'sd0, 1'b0));
    dir_rows.push_back(row(16'sd2, 1'b0));
    dir_rows.push_back(row(16'sd0, 1'b0));
    dir_rows.push_back(row(16'sd10, 1'b0));
    dir_rows.push_back(row(16'sd20, 1'b0));
    dir_rows.push_back(row(16'sd30, 1'b1));
    // flat run with zero step
    dir_rows.push_back(row(16'sd5, 1'b0));
    dir_rows.push_back(row(16'sd5, 1'b0));
    dir_rows.push_back(row(16'sd5, 1'b0));
    dir_rows.push_back(typed_row(16'sd5, run_word(0, 3, 4, 0, 1'b0)));
    // falling then rising keeps the absolute step
    dir_rows.push_back(row(16'sd10, 1'b0));
    dir_rows.push_back(row(16'sd7, 1'b0));
    dir_rows.push_back(row(16'sd4, 1'b0));
    dir_rows.push_back(row(16'sd7, 1'b1));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(negedge clk_i);

    foreach (dir_rows[i])
      push_sample(dir_rows[i].smp, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    run_phase(24, 51, 1'b0);
    run_phase(51, 24, 1'b1);
    run_phase(0, 0, 1'b0);
    repeat (10) @(posedge clk_i);

    $display("covered %0d sequences in %0d samples, %0d run words checked", n_seqs,
             n_samples, n_results);
    $display("with sender and receiver stalls and a long output hold-off");
    if (n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
